/* hw/rtl/frame_slot_manager_drop_oldest_core_defines.svh */
// ---------------------------------------------------------------------------
// Frame slot manager assertion macros
// Shared assertion forms. They use clk and rst of the enclosing module.
// ---------------------------------------------------------------------------
`ifndef FRAME_SLOT_MANAGER_DROP_OLDEST_CORE_DEFINES_SVH
`define FRAME_SLOT_MANAGER_DROP_OLDEST_CORE_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define FSMDO_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that follows in the same cycle.
`define FSMDO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that follows in the next cycle.
`define FSMDO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/fsmdo_pkg.sv */
// ---------------------------------------------------------------------------
// Frame slot manager package
// Field widths, request and status codes and register indexes.
// ---------------------------------------------------------------------------
package fsmdo_pkg;

  localparam int SLOT_W     = 8;
  localparam int CNT_W      = 9;
  localparam int STAT_W     = 32;
  localparam int REQ_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY    = 1'd1;

  localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 9'd200;
  localparam logic [CNT_W-1:0] MIN_SLOTS      = 9'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ACQUIRE    = 3'd0,
    REQ_COMMIT     = 3'd1,
    REQ_ABORT      = 3'd2,
    REQ_TAKE       = 3'd3,
    REQ_RELEASE    = 3'd4,
    REQ_PUTBACK    = 3'd5,
    REQ_FLUSH      = 3'd6,
    REQ_FLUSH_COND = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERR   = 2'd2
  } status_t;

endpackage

/* hw/rtl/fsmdo_if.sv */
// ---------------------------------------------------------------------------
// Frame slot manager channels
// Request and response channels with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface fsmdo_req_if import fsmdo_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output req_type, output slot, input ready);
  modport sink   (input valid, input req_type, input slot, output ready);
endinterface

interface fsmdo_rsp_if import fsmdo_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [SLOT_W-1:0] granted_slot;
  logic              sacrificed;
  logic [CNT_W-1:0]  queued_now;
  logic [CNT_W-1:0]  free_now;
  logic [CNT_W-1:0]  queue_peak;
  logic [STAT_W-1:0] drop_streak_max;
  logic [STAT_W-1:0] drops_overall;
  logic [STAT_W-1:0] flushes_done;

  modport source (output valid, output status, output granted_slot, output sacrificed,
                  output queued_now, output free_now, output queue_peak,
                  output drop_streak_max, output drops_overall, output flushes_done,
                  input ready);
  modport sink   (input valid, input status, input granted_slot, input sacrificed,
                  input queued_now, input free_now, input queue_peak,
                  input drop_streak_max, input drops_overall, input flushes_done,
                  output ready);
endinterface

/* hw/rtl/fsmdo_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module fsmdo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/frame_slot_manager_drop_oldest_core.sv */
// Sequence: a request that only writes a link, or touches none, passes the evaluate and put
// states; acquire and take read a link and pass the link state between the two.
// Requests are worked one at a time: a new one is taken only back in idle, after the
// previous word is registered; a stalled response holds the sequencer in turn.
// Reset (rst, synchronous): all slots become free, holders go idle, statistics clear; the
// link RAM needs no clearing pass as per-entry valid bits clear at once.
// ---------------------------------------------------------------------------
// Frame slot manager, drop-oldest policy
// Free list and FIFO queue of frame slots sharing one link RAM, run by a small sequencer.
// ---------------------------------------------------------------------------
`include "frame_slot_manager_drop_oldest_core_defines.svh"

module frame_slot_manager_drop_oldest_core import fsmdo_pkg::*; #(
  parameter int NUM_SLOTS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  fsmdo_req_if.sink             req,
  fsmdo_rsp_if.source           rsp
);

  // Slot indices are eight bits wide, so no more than 256 link entries are ever reached.
  localparam int DEPTH = (NUM_SLOTS < 256) ? NUM_SLOTS : 256;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_LINK,
    S_PUT
  } state_t;

  // Clamp a slot count to the range the hardware can hold.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(DEPTH);
    if (v < MIN_SLOTS) begin
      return MIN_SLOTS;
    end else if (v > lim) begin
      return lim;
    end
    return v;
  endfunction

  state_t            state;

  // Configuration.
  logic [CNT_W-1:0]  slot_count;
  logic              history_enable;

  // List heads, tails and sizes.
  logic [SLOT_W-1:0] free_first, free_last;
  logic [CNT_W-1:0]  free_size;
  logic [SLOT_W-1:0] queue_first, queue_last;
  logic [CNT_W-1:0]  queue_size;
  logic [SLOT_W-1:0] producer_slot, consumer_slot;
  logic              producer_busy, consumer_busy;

  // Statistics.
  logic [CNT_W-1:0]  peak_queue;
  logic [STAT_W-1:0] streak_now, streak_peak, drops_sum, flush_sum;

  // Request being worked on and its partial result.
  req_t              req_q;
  logic [SLOT_W-1:0] slot_q;
  status_t           ev_status;
  logic [SLOT_W-1:0] ev_grant;
  logic              ev_stole;
  logic              lk_queue;

  // Link RAM and its per-entry valid bits. An entry that has never been written since the
  // last rebuild reads as its own index plus one, which is the initial chain.
  logic [DEPTH-1:0]  link_vld;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [SLOT_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [SLOT_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr_q;
  logic              rd_vld;
  logic [SLOT_W-1:0] link_val;

  // Output register.
  logic              o_valid;
  status_t           o_status;
  logic [SLOT_W-1:0] o_grant;
  logic              o_stole;
  logic [CNT_W-1:0]  o_queued, o_free, o_peak;
  logic [STAT_W-1:0] o_streak_max, o_drops, o_flushes;

  // Decoded conditions of the current request.
  logic              acq_ok, acq_free, prod_ok, cons_ok, flush_go;
  logic [CNT_W-1:0]  eff_count, rebuild_count;
  logic [CNT_W-1:0]  peak_next;
  logic [STAT_W-1:0] streak_peak_next;

  // Terms used by the checks at the end.
  logic [CNT_W:0]    slots_held;
  logic              eval_no_grant;
  logic              req_go;

  // The one shared saturating incrementer serves the drop, flush and streak counters in
  // turn: drops and flushes in the evaluate cycle, the streak in the link cycle.
  logic [STAT_W-1:0] inc_in, inc_out;

  always_comb begin
    if (state == S_LINK) begin
      inc_in = streak_now;
    end else if (req_q == REQ_ACQUIRE) begin
      inc_in = drops_sum;
    end else begin
      inc_in = flush_sum;
    end
    inc_out = (&inc_in) ? inc_in : inc_in + STAT_W'(1);
  end

  assign acq_ok   = !producer_busy && (free_size != '0 || queue_size != '0);
  assign acq_free = free_size != '0;
  assign prod_ok  = producer_busy && slot_q == producer_slot;
  assign cons_ok  = consumer_busy && slot_q == consumer_slot;
  assign flush_go = req_q == REQ_FLUSH || (req_q == REQ_FLUSH_COND && !history_enable);

  assign eff_count     = clamp_count(slot_count);
  assign rebuild_count = rst ? clamp_count(SLOT_COUNT_RST) : clamp_count(cfg_wdata);

  assign peak_next        = (queue_size > peak_queue) ? queue_size : peak_queue;
  assign streak_peak_next = (streak_now > streak_peak) ? streak_now : streak_peak;

  // Every request needs at most one link access: a read for the pops of acquire and take,
  // a write for the pushes and for joining the queue onto the free list.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_q[AW-1:0];
    mem_wdata = free_first;
    unique case (req_q)
      REQ_COMMIT: begin
        mem_we    = prod_ok && queue_size != '0;
        mem_waddr = queue_last[AW-1:0];
        mem_wdata = slot_q;
      end
      REQ_ABORT, REQ_RELEASE: begin
        mem_we    = (req_q == REQ_ABORT) ? prod_ok : cons_ok;
        mem_waddr = slot_q[AW-1:0];
        mem_wdata = free_first;
      end
      REQ_PUTBACK: begin
        mem_we    = cons_ok;
        mem_waddr = slot_q[AW-1:0];
        mem_wdata = queue_first;
      end
      REQ_FLUSH, REQ_FLUSH_COND: begin
        mem_we    = flush_go && queue_size != '0 && free_size != '0;
        mem_waddr = free_last[AW-1:0];
        mem_wdata = queue_first;
      end
      REQ_ACQUIRE, REQ_TAKE: begin
        mem_we = 1'b0;
      end
    endcase
    if (state != S_EVAL) begin
      mem_we = 1'b0;
    end
  end

  assign mem_raddr = (req_q == REQ_ACQUIRE && acq_free) ? free_first[AW-1:0]
                                                        : queue_first[AW-1:0];

  fsmdo_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_links (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  assign link_val = rd_vld ? rd_data : (SLOT_W'(rd_addr_q) + SLOT_W'(1));

  // Read address and valid bit are captured with the RAM's own read register.
  always_ff @(posedge clk) begin
    rd_addr_q <= mem_raddr;
    rd_vld    <= link_vld[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      o_valid        <= 1'b0;
      slot_count     <= SLOT_COUNT_RST;
      history_enable <= 1'b0;
      peak_queue     <= '0;
      streak_now     <= '0;
      streak_peak    <= '0;
      drops_sum      <= '0;
      flush_sum      <= '0;
    end else begin
      // The output register empties here unless the sequencer refills it in this cycle.
      if (o_valid && rsp.ready && state != S_PUT) begin
        o_valid <= 1'b0;
      end
      if (mem_we) begin
        link_vld[mem_waddr] <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_q  <= req_t'(req.req_type);
            slot_q <= req.slot;
            state  <= S_EVAL;
          end
        end

        S_EVAL: begin
          ev_status <= ST_OK;
          ev_grant  <= '0;
          ev_stole  <= 1'b0;
          lk_queue  <= 1'b0;
          state     <= S_PUT;
          unique case (req_q)
            REQ_ACQUIRE: begin
              if (acq_ok) begin
                producer_busy <= 1'b1;
                state         <= S_LINK;
                if (acq_free) begin
                  ev_grant      <= free_first;
                  producer_slot <= free_first;
                  free_size     <= free_size - CNT_W'(1);
                  streak_now    <= '0;
                end else begin
                  // Free list empty: the oldest queued frame is dropped and reused.
                  ev_grant      <= queue_first;
                  producer_slot <= queue_first;
                  queue_size    <= queue_size - CNT_W'(1);
                  ev_stole      <= 1'b1;
                  lk_queue      <= 1'b1;
                  drops_sum     <= inc_out;
                end
              end else begin
                ev_status <= ST_ERR;
              end
            end
            REQ_COMMIT: begin
              if (prod_ok) begin
                if (queue_size == '0) begin
                  queue_first <= slot_q;
                end
                queue_last    <= slot_q;
                queue_size    <= queue_size + CNT_W'(1);
                producer_busy <= 1'b0;
                producer_slot <= '0;
              end else begin
                ev_status <= ST_ERR;
              end
            end
            REQ_ABORT: begin
              if (prod_ok) begin
                free_first <= slot_q;
                if (free_size == '0) begin
                  free_last <= slot_q;
                end
                free_size     <= free_size + CNT_W'(1);
                producer_busy <= 1'b0;
                producer_slot <= '0;
              end else begin
                ev_status <= ST_ERR;
              end
            end
            REQ_TAKE: begin
              if (consumer_busy) begin
                ev_status <= ST_ERR;
              end else if (queue_size == '0) begin
                ev_status <= ST_EMPTY;
              end else begin
                ev_grant      <= queue_first;
                consumer_slot <= queue_first;
                consumer_busy <= 1'b1;
                queue_size    <= queue_size - CNT_W'(1);
                lk_queue      <= 1'b1;
                state         <= S_LINK;
              end
            end
            REQ_RELEASE: begin
              if (cons_ok) begin
                free_first <= slot_q;
                if (free_size == '0) begin
                  free_last <= slot_q;
                end
                free_size     <= free_size + CNT_W'(1);
                consumer_busy <= 1'b0;
                consumer_slot <= '0;
              end else begin
                ev_status <= ST_ERR;
              end
            end
            REQ_PUTBACK: begin
              if (cons_ok) begin
                queue_first <= slot_q;
                if (queue_size == '0) begin
                  queue_last <= slot_q;
                end
                queue_size    <= queue_size + CNT_W'(1);
                consumer_busy <= 1'b0;
                consumer_slot <= '0;
              end else begin
                ev_status <= ST_ERR;
              end
            end
            REQ_FLUSH, REQ_FLUSH_COND: begin
              if (flush_go) begin
                if (queue_size != '0) begin
                  if (free_size == '0) begin
                    free_first <= queue_first;
                  end
                  free_last  <= queue_last;
                  free_size  <= free_size + queue_size;
                  queue_size <= '0;
                end
                flush_sum <= inc_out;
              end
            end
          endcase
        end

        S_LINK: begin
          if (lk_queue) begin
            queue_first <= link_val;
          end else begin
            free_first <= link_val;
          end
          if (ev_stole) begin
            streak_now <= inc_out;
          end
          state <= S_PUT;
        end

        S_PUT: begin
          if (!o_valid || rsp.ready) begin
            o_valid      <= 1'b1;
            o_status     <= ev_status;
            o_grant      <= ev_grant;
            o_stole      <= ev_stole;
            o_queued     <= queue_size;
            o_free       <= free_size;
            o_peak       <= peak_next;
            o_streak_max <= streak_peak_next;
            o_drops      <= drops_sum;
            o_flushes    <= flush_sum;
            peak_queue   <= peak_next;
            streak_peak  <= streak_peak_next;
            state        <= S_IDLE;
          end
        end
      endcase

      if (cfg_we && cfg_index == REG_HISTORY) begin
        history_enable <= cfg_wdata[0];
      end
      if (cfg_we && cfg_index == REG_SLOT_COUNT) begin
        slot_count <= cfg_wdata;
      end
    end

    // Reset and a slot count write both rebuild the lists; statistics survive the latter.
    if (rst || (cfg_we && cfg_index == REG_SLOT_COUNT)) begin
      link_vld      <= '0;
      free_first    <= '0;
      free_size     <= rebuild_count;
      free_last     <= SLOT_W'(rebuild_count - CNT_W'(1));
      queue_first   <= '0;
      queue_last    <= '0;
      queue_size    <= '0;
      producer_slot <= '0;
      producer_busy <= 1'b0;
      consumer_slot <= '0;
      consumer_busy <= 1'b0;
    end
  end

  assign req.ready = (state == S_IDLE);

  assign rsp.valid           = o_valid;
  assign rsp.status          = o_status;
  assign rsp.granted_slot    = o_grant;
  assign rsp.sacrificed      = o_stole;
  assign rsp.queued_now      = o_queued;
  assign rsp.free_now        = o_free;
  assign rsp.queue_peak      = o_peak;
  assign rsp.drop_streak_max = o_streak_max;
  assign rsp.drops_overall   = o_drops;
  assign rsp.flushes_done    = o_flushes;

  assign slots_held    = (CNT_W+1)'(free_size) + (CNT_W+1)'(queue_size)
                       + (CNT_W+1)'(producer_busy) + (CNT_W+1)'(consumer_busy);
  assign eval_no_grant = state == S_EVAL && req_q != REQ_ACQUIRE && !producer_busy && !cfg_we;
  assign req_go        = req.valid && req.ready && !cfg_we;

  // Every slot in use is in exactly one place: free list, queue, or with a holder.
  `FSMDO_ASSERT_ALWAYS(a_slots_conserved, slots_held == (CNT_W+1)'(eff_count), "slot lost")
  // Only an acquire can hand a slot to the producer.
  `FSMDO_ASSERT_NEXT(a_producer_by_acquire, eval_no_grant, !producer_busy, "busy without acquire")
  // A request is worked on alone: the sequencer leaves idle as soon as one is taken.
  `FSMDO_ASSERT_NEXT(a_one_at_a_time, req_go, state == S_EVAL, "request not started")

endmodule
